/* hw/rtl/lpri_pkg.sv */
package lpri_pkg;

    localparam int CMD_W      = 2;
    localparam int RING_W     = 6;
    localparam int POS_W      = 21;
    localparam int CRD_W      = 12;
    localparam int PIX_W      = 8;
    localparam int S_TDATA_W  = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_POINT = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 3'd5;

    localparam logic [6:0]  RST_RING_COUNT = 7'd32;
    localparam logic [11:0] RST_COLS       = 12'd1092;
    localparam logic [10:0] RST_CROP_START = 11'd409;
    localparam logic [11:0] RST_CROP_WIDTH = 12'd273;
    localparam logic [11:0] RST_OUT_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_OUT_HEIGHT = 12'd720;

    localparam logic [PIX_W-1:0] EMPTY_PIXEL = 8'd255;
    localparam logic [15:0] HALF_TURN = 16'd32768;

    localparam int SQ_W    = 42;
    localparam int ROOT_W  = 21;
    localparam int DIV_N_W = 24;
    localparam int DIV_D_W = 12;

    typedef struct packed {
        t_op                      op;
        logic [RING_W-1:0]        ring;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [CRD_W-1:0]         out_col;
        logic [CRD_W-1:0]         out_row;
    } t_item;

    typedef struct packed {
        logic [6:0]  ring_count;
        logic [11:0] columns_per_ring;
        logic [10:0] crop_start;
        logic [11:0] crop_width;
        logic [11:0] out_width;
        logic [11:0] out_height;
    } t_cfg;

    function automatic logic [13:0] atan_turn(input logic [3:0] idx);
        logic [13:0] v;
        case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/lidar_point_to_range_image_top.sv */
// Lidar range image builder. A stream of requests (tuser: 0 clear, 1 write point,
// 2 read pixel) drives an 8-bit image of MAX_ROWS x MAX_COLS pixels held in one
// on-chip single-port memory. Requests enter a four-deep queue, so the input side
// keeps accepting while the execution side works until it is full; only reads
// return a result. After reset, and for every clear request, the memory is swept
// to 255 at one pixel per cycle. No request is taken during the sweep after
// reset; configuration writes are taken at all times. A point write waits for the
// longer of the square-root unit and the azimuth unit (up to 28 normalizing
// shifts, then 16 CORDIC steps); a point whose ring is out of range, or with no
// columns configured, is dropped without a write. A read runs two 24-bit
// divisions one after the other in one shared serial divider; out-of-range
// coordinates, zero rows and an empty crop answer without dividing.
module lidar_point_to_range_image_top import lpri_pkg::*; #(
    parameter int MAX_ROWS        = 64,
    parameter int MAX_COLS        = 2048,
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // ring[5:0], pos_x[26:6], pos_y[47:27], invalid[48], out_col[60:49], out_row[72:61]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]      i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // pixel[7:0]
    output logic [PIX_W-1:0]      o_m_tdata,
    // coord_error[0]
    output logic [0:0]            o_m_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_q_valid, w_q_pop, w_init_busy, w_m_err;
    t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_count       <= RST_RING_COUNT;
            r_cfg.columns_per_ring <= RST_COLS;
            r_cfg.crop_start       <= RST_CROP_START;
            r_cfg.crop_width       <= RST_CROP_WIDTH;
            r_cfg.out_width        <= RST_OUT_WIDTH;
            r_cfg.out_height       <= RST_OUT_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RING_COUNT: r_cfg.ring_count       <= i_cfg_data[6:0];
                CFG_COLS:       r_cfg.columns_per_ring <= i_cfg_data;
                CFG_CROP_START: r_cfg.crop_start       <= i_cfg_data[10:0];
                CFG_CROP_WIDTH: r_cfg.crop_width       <= i_cfg_data;
                CFG_OUT_WIDTH:  r_cfg.out_width        <= i_cfg_data;
                CFG_OUT_HEIGHT: r_cfg.out_height       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lpri_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_hold     (w_init_busy),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    lpri_back #(
        .MAX_ROWS        (MAX_ROWS),
        .MAX_COLS        (MAX_COLS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_init_busy (w_init_busy),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_m_pixel   (o_m_tdata),
        .o_m_err     (w_m_err)
    );

    assign o_m_tuser = w_m_err;

endmodule

/* hw/rtl/lpri_front.sv */
module lpri_front import lpri_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic                 i_hold,
    output logic                 o_q_valid,
    output t_item                o_q_item,
    input  logic                 i_q_pop
);

    localparam int QD = 4;

    t_item      r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_acc, w_push;
    t_item      w_item;

    assign o_s_tready = (r_cnt != 3'(QD)) && !i_hold;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        w_item.ring    = i_s_tdata[5:0];
        w_item.pos_x   = i_s_tdata[26:6];
        w_item.pos_y   = i_s_tdata[47:27];
        w_item.out_col = i_s_tdata[60:49];
        w_item.out_row = i_s_tdata[72:61];
        w_item.op      = OP_CLEAR;
        w_push         = 1'b0;
        unique case (i_s_tuser)
            CMD_CLEAR: begin
                w_item.op = OP_CLEAR;
                w_push    = w_acc;
            end
            CMD_POINT: begin
                w_item.op = OP_POINT;
                w_push    = w_acc && !i_s_tdata[48];
            end
            CMD_READ: begin
                w_item.op = OP_READ;
                w_push    = w_acc;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (i_q_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(i_q_pop);
        end
    end

endmodule

/* hw/rtl/lpri_cordic.sv */
module lpri_cordic import lpri_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [POS_W-1:0] i_x,
    input  logic signed [POS_W-1:0] i_y,
    output logic                    o_busy,
    output logic [15:0]             o_phase
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]         r_state;
    logic signed [32:0] r_x, r_y;
    logic [28:0]        r_m;
    logic signed [17:0] r_z;
    logic [3:0]         r_i;
    logic               r_fold;
    logic [15:0]        r_phase;
    logic [POS_W-1:0]   w_ax, w_ay;
    logic signed [32:0] w_dx, w_dy;
    logic signed [19:0] w_p;

    assign w_ax = i_x[POS_W-1] ? POS_W'(-i_x) : POS_W'(i_x);
    assign w_ay = i_y[POS_W-1] ? POS_W'(-i_y) : POS_W'(i_y);
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;

    always_comb begin
        if (!r_fold) w_p = 20'sd32768 + 20'(r_z);
        else if (r_y[32]) w_p = 20'sd65536 + 20'(r_z);
        else w_p = 20'(r_z);
    end

    assign o_busy  = (r_state != C_IDLE);
    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (i_x == '0 && i_y == '0) begin
                            r_phase <= HALF_TURN;
                        end else begin
                            r_x     <= 33'(i_x);
                            r_y     <= 33'(i_y);
                            r_m     <= (w_ax > w_ay) ? 29'(w_ax) : 29'(w_ay);
                            r_fold  <= i_x[POS_W-1];
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (!r_m[28]) begin
                        r_m <= {r_m[27:0], 1'b0};
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        if (r_fold) begin
                            r_x <= -r_x;
                            r_y <= -r_y;
                        end
                        r_z     <= '0;
                        r_i     <= '0;
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    if (!r_y[32]) begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + 18'(atan_turn(r_i));
                    end else begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - 18'(atan_turn(r_i));
                    end
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd15) r_state <= C_FIN;
                end
                C_FIN: begin
                    if (w_p < 0) r_phase <= '0;
                    else if (w_p > 20'sd65535) r_phase <= 16'hFFFF;
                    else r_phase <= w_p[15:0];
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/lpri_isqrt.sv */
module lpri_isqrt import lpri_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_s,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 3;

    logic [SQ_W-1:0]   r_s;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic [REM_W-1:0]  w_rem, w_trial;

    assign w_rem   = {r_rem[REM_W-3:0], r_s[SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign o_busy  = r_busy;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_s    <= i_s;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_s <= {r_s[SQ_W-3:0], 2'b00};
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(ROOT_W - 1)) r_busy <= 1'b0;
        end
    end

endmodule

/* hw/rtl/lpri_div.sv */
module lpri_div import lpri_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_busy,
    output logic [DIV_N_W-1:0] o_quot
);

    logic [DIV_N_W-1:0] r_n;
    logic [DIV_D_W-1:0] r_rem, r_d;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic [DIV_D_W:0]   w_sh, w_diff;
    logic               w_ge;

    assign w_sh   = {r_rem, r_n[DIV_N_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_d});
    assign w_diff = w_sh - {1'b0, r_d};
    assign o_busy = r_busy;
    assign o_quot = r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_n    <= i_num;
            r_d    <= i_den;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_sh[DIV_D_W-1:0];
            r_n   <= {r_n[DIV_N_W-2:0], w_ge};
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(DIV_N_W - 1)) r_busy <= 1'b0;
        end
    end

endmodule

/* hw/rtl/lpri_back.sv */
module lpri_back import lpri_pkg::*; #(
    parameter int MAX_ROWS        = 64,
    parameter int MAX_COLS        = 2048,
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_init_busy,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output logic [PIX_W-1:0] o_m_pixel,
    output logic             o_m_err
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int R_W    = $clog2(MAX_ROWS + 1);
    localparam int C_W    = $clog2(MAX_COLS + 1);
    localparam int PR_W   = 16 + C_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_PT_MUL  = 4'd2;
    localparam logic [3:0] S_PT_SQ   = 4'd3;
    localparam logic [3:0] S_PT_RUN  = 4'd4;
    localparam logic [3:0] S_PT_BIN  = 4'd5;
    localparam logic [3:0] S_PT_WR   = 4'd6;
    localparam logic [3:0] S_RD_CHK  = 4'd7;
    localparam logic [3:0] S_RD_DIV1 = 4'd8;
    localparam logic [3:0] S_RD_DIV2 = 4'd9;
    localparam logic [3:0] S_RD_ADR  = 4'd10;
    localparam logic [3:0] S_RD_DAT  = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0]          r_state;
    logic                r_init;
    logic [ADDR_W-1:0]   r_clr;
    t_item               r_item;
    logic [SQ_W-1:0]     r_xx, r_yy;
    logic [R_W-1:0]      r_row;
    logic                r_pi;
    logic [PR_W-1:0]     r_prod;
    logic [DIV_N_W-1:0]  r_sr;
    logic [DIV_N_W:0]    r_sc;
    logic [PIX_W-1:0]    r_res_pix;
    logic                r_res_err;
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_out_pix;
    logic                r_out_err;
    logic [PIX_W-1:0]    r_mem [DEPTH];
    logic [PIX_W-1:0]    r_rdata;

    logic [R_W-1:0]      w_rows;
    logic [C_W-1:0]      w_cols, w_bin, w_col;
    logic                w_pt_ok, w_rd_err, w_rd_empty, w_out_free;
    logic signed [SQ_W-1:0] w_px2, w_py2;
    logic                w_az_busy, w_sq_busy, w_div_busy, w_div_start;
    logic [15:0]         w_phase;
    logic [ROOT_W-1:0]   w_root, w_rng;
    logic [PIX_W-1:0]    w_rng_pix;
    logic [DIV_N_W-1:0]  w_div_num, w_quot;
    logic [DIV_D_W-1:0]  w_div_den;
    logic                w_we, w_re, w_src_ok;
    logic [ADDR_W-1:0]   w_addr;
    logic [PIX_W-1:0]    w_wdata;

    assign w_rows = ({1'b0, i_cfg.ring_count} < 8'(MAX_ROWS)) ?
                    R_W'(i_cfg.ring_count) : R_W'(MAX_ROWS);
    assign w_cols = ({1'b0, i_cfg.columns_per_ring} < 13'(MAX_COLS)) ?
                    C_W'(i_cfg.columns_per_ring) : C_W'(MAX_COLS);

    assign w_pt_ok    = (8'(r_item.ring) < 8'(w_rows)) && (w_cols != '0);
    assign w_px2      = r_item.pos_x * r_item.pos_x;
    assign w_py2      = r_item.pos_y * r_item.pos_y;
    assign w_rd_err   = (r_item.out_col >= i_cfg.out_width) ||
                        (r_item.out_row >= i_cfg.out_height);
    assign w_rd_empty = (w_rows == '0) || (i_cfg.crop_width == '0);
    assign w_out_free = !r_out_valid || i_m_ready;

    assign w_rng     = w_root >> COORD_FRAC_BITS;
    assign w_rng_pix = (|w_rng[ROOT_W-1:PIX_W]) ? EMPTY_PIXEL : w_rng[PIX_W-1:0];
    assign w_bin     = r_prod[16 +: C_W];
    assign w_col     = r_pi ? '0 : C_W'(w_cols - C_W'(1) - w_bin);
    assign w_src_ok  = (r_sc < (DIV_N_W + 1)'(w_cols)) && (r_sr < DIV_N_W'(w_rows));

    assign w_div_start = (r_state == S_RD_CHK && !w_rd_err && !w_rd_empty) ||
                         (r_state == S_RD_DIV1 && !w_div_busy);
    assign w_div_num = (r_state == S_RD_CHK) ?
                       DIV_N_W'(r_item.out_row) * DIV_N_W'(w_rows) :
                       DIV_N_W'(r_item.out_col) * DIV_N_W'(i_cfg.crop_width);
    assign w_div_den = (r_state == S_RD_CHK) ? i_cfg.out_height : i_cfg.out_width;

    lpri_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PT_SQ),
        .i_x     (r_item.pos_x),
        .i_y     (r_item.pos_y),
        .o_busy  (w_az_busy),
        .o_phase (w_phase)
    );

    lpri_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PT_SQ),
        .i_s     (r_xx + r_yy),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    lpri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wdata = w_rng_pix;
        w_addr  = ADDR_W'(r_sr[R_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(r_sc[C_W-1:0]);
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = EMPTY_PIXEL;
                w_addr  = r_clr;
            end
            S_PT_WR: begin
                w_we   = 1'b1;
                w_addr = ADDR_W'(r_row) * ADDR_W'(MAX_COLS) + ADDR_W'(w_col);
            end
            S_RD_ADR: begin
                w_re = w_src_ok;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_addr];
    end

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_init_busy = r_init;
    assign o_m_valid   = r_out_valid;
    assign o_m_pixel   = r_out_pix;
    assign o_m_err     = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_pix   <= r_res_pix;
                r_out_err   <= r_res_err;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        case (i_q_item.op)
                            OP_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            OP_POINT: r_state <= S_PT_MUL;
                            OP_READ:  r_state <= S_RD_CHK;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (r_clr == LAST_ADDR) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + ADDR_W'(1);
                    end
                end
                S_PT_MUL: begin
                    r_xx  <= w_px2;
                    r_yy  <= w_py2;
                    r_row <= R_W'(w_rows - R_W'(1) - R_W'(r_item.ring));
                    r_pi  <= (r_item.pos_y == '0) && r_item.pos_x[POS_W-1];
                    r_state <= w_pt_ok ? S_PT_SQ : S_IDLE;
                end
                S_PT_SQ: r_state <= S_PT_RUN;
                S_PT_RUN: begin
                    if (!w_az_busy && !w_sq_busy) r_state <= S_PT_BIN;
                end
                S_PT_BIN: begin
                    r_prod  <= PR_W'(w_phase) * PR_W'(w_cols);
                    r_state <= S_PT_WR;
                end
                S_PT_WR: r_state <= S_IDLE;
                S_RD_CHK: begin
                    if (w_rd_err) begin
                        r_res_pix <= '0;
                        r_res_err <= 1'b1;
                        r_state   <= S_OUT;
                    end else if (w_rd_empty) begin
                        r_res_pix <= EMPTY_PIXEL;
                        r_res_err <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_RD_DIV1;
                    end
                end
                S_RD_DIV1: begin
                    if (!w_div_busy) begin
                        r_sr    <= w_quot;
                        r_state <= S_RD_DIV2;
                    end
                end
                S_RD_DIV2: begin
                    if (!w_div_busy) begin
                        r_sc    <= (DIV_N_W + 1)'(i_cfg.crop_start) + (DIV_N_W + 1)'(w_quot);
                        r_state <= S_RD_ADR;
                    end
                end
                S_RD_ADR: begin
                    r_res_err <= 1'b0;
                    if (w_src_ok) begin
                        r_state <= S_RD_DAT;
                    end else begin
                        r_res_pix <= EMPTY_PIXEL;
                        r_state   <= S_OUT;
                    end
                end
                S_RD_DAT: begin
                    r_res_pix <= r_rdata;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
